[rtl/srl_pkg.sv]
package srl_pkg;

   localparam int unsigned ADDR_BYTES = 2;
   localparam logic [7:0]  LEN_OVERHEAD = 8'(ADDR_BYTES + 1);
   localparam logic [7:0]  ADDR_COUNT = 8'(ADDR_BYTES);

   localparam logic [7:0] CHAR_S  = 8'h53;
   localparam logic [7:0] CHAR_0  = 8'h30;
   localparam logic [7:0] CHAR_1  = 8'h31;
   localparam logic [7:0] CHAR_2  = 8'h32;
   localparam logic [7:0] CHAR_9  = 8'h39;
   localparam logic [7:0] CHAR_UA = 8'h41;
   localparam logic [7:0] CHAR_UF = 8'h46;
   localparam logic [7:0] CHAR_LA = 8'h61;
   localparam logic [7:0] CHAR_LF = 8'h66;

   localparam logic [3:0] REC_NAME  = 4'd0;
   localparam logic [3:0] REC_INSTR = 4'd1;
   localparam logic [3:0] REC_DATA  = 4'd2;
   localparam logic [3:0] REC_START = 4'd9;
   localparam logic [3:0] REC_OTHER = 4'd15;

   localparam logic [7:0] SUM_GOOD = 8'hFF;

   typedef enum logic [3:0] {
      PH_S    = 4'd0,
      PH_TYPE = 4'd1,
      PH_LEN  = 4'd2,
      PH_ADDR = 4'd3,
      PH_DATA = 4'd4,
      PH_CHK  = 4'd5,
      PH_TERM = 4'd6,
      PH_DONE = 4'd7,
      PH_HALT = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      KIND_INSTR = 3'd0,
      KIND_DATA  = 3'd1,
      KIND_NAME  = 3'd2,
      KIND_END   = 3'd3,
      KIND_DONE  = 3'd4,
      KIND_ERR   = 3'd5
   } kind_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [15:0] location;
      logic [7:0]  byte_value;
      logic        checksum_ok;
   } result_type;

   // bit 4: digit is valid, bits 3:0: nibble value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      begin
         case (c) inside
            [CHAR_0:CHAR_9]:   r = {1'b1, 4'(c - CHAR_0)};
            [CHAR_UA:CHAR_UF]: r = {1'b1, 4'(c - CHAR_UA + 8'd10)};
            [CHAR_LA:CHAR_LF]: r = {1'b1, 4'(c - CHAR_LA + 8'd10)};
            default:           r = 5'd0;
         endcase
         return r;
      end
   endfunction

endpackage

[rtl/srl_parser.sv]
module srl_parser
   import srl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] char_in,
   input  logic       new_load,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  rec_type_ff, rec_type_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [15:0] rec_addr_ff, rec_addr_in;
   logic [7:0]  sum_ff, sum_in;
   logic [3:0]  high_nib_ff, high_nib_in;
   logic        nib_pend_ff, nib_pend_in;

   phase_type   ph;
   logic [3:0]  cur_type;
   logic [7:0]  cur_left;
   logic [7:0]  cur_index;
   logic [15:0] cur_addr;
   logic [7:0]  cur_sum;
   logic [3:0]  cur_high;
   logic        cur_pend;
   logic [4:0]  hex;
   logic [7:0]  data_byte;
   logic [7:0]  sum_next;
   logic [7:0]  index_inc;
   logic [7:0]  left_dec;

   always_comb begin
      ph        = new_load ? PH_S : phase_ff;
      cur_type  = new_load ? 4'd0 : rec_type_ff;
      cur_left  = new_load ? 8'd0 : bytes_left_ff;
      cur_index = new_load ? 8'd0 : byte_index_ff;
      cur_addr  = new_load ? 16'd0 : rec_addr_ff;
      cur_sum   = new_load ? 8'd0 : sum_ff;
      cur_high  = new_load ? 4'd0 : high_nib_ff;
      cur_pend  = new_load ? 1'b0 : nib_pend_ff;

      hex       = hex_decode(char_in);
      data_byte = {cur_high, hex[3:0]};
      sum_next  = cur_sum + data_byte;
      index_inc = cur_index + 8'd1;
      left_dec  = cur_left - 8'd1;

      phase_in      = ph;
      rec_type_in   = cur_type;
      bytes_left_in = cur_left;
      byte_index_in = cur_index;
      rec_addr_in   = cur_addr;
      sum_in        = cur_sum;
      high_nib_in   = cur_high;
      nib_pend_in   = cur_pend;

      result = '{valid: 1'b0, kind: KIND_END, location: 16'd0,
                 byte_value: 8'd0, checksum_ok: 1'b0};

      case (ph)
         PH_S: begin
            if (char_in != CHAR_S) begin
               phase_in     = PH_HALT;
               result.valid = 1'b1;
               result.kind  = KIND_ERR;
            end else begin
               sum_in      = 8'd0;
               rec_addr_in = 16'd0;
               nib_pend_in = 1'b0;
               phase_in    = PH_TYPE;
            end
         end
         PH_TYPE: begin
            case (char_in)
               CHAR_0:  rec_type_in = REC_NAME;
               CHAR_1:  rec_type_in = REC_INSTR;
               CHAR_2:  rec_type_in = REC_DATA;
               CHAR_9:  rec_type_in = REC_START;
               default: rec_type_in = REC_OTHER;
            endcase
            phase_in = PH_LEN;
         end
         PH_LEN, PH_ADDR, PH_DATA, PH_CHK: begin
            if (!hex[4]) begin
               phase_in     = PH_HALT;
               result.valid = 1'b1;
               result.kind  = KIND_ERR;
            end else if (!cur_pend) begin
               high_nib_in = hex[3:0];
               nib_pend_in = 1'b1;
            end else begin
               nib_pend_in = 1'b0;
               sum_in      = sum_next;
               case (ph)
                  PH_LEN: begin
                     bytes_left_in = (data_byte >= LEN_OVERHEAD) ?
                                     data_byte - LEN_OVERHEAD : 8'd0;
                     byte_index_in = 8'd0;
                     rec_addr_in   = 16'd0;
                     phase_in      = PH_ADDR;
                  end
                  PH_ADDR: begin
                     rec_addr_in   = {cur_addr[7:0], data_byte};
                     byte_index_in = index_inc;
                     if (index_inc >= ADDR_COUNT) begin
                        byte_index_in = 8'd0;
                        phase_in      = (cur_left != 8'd0) ? PH_DATA : PH_CHK;
                     end
                  end
                  PH_DATA: begin
                     byte_index_in = index_inc;
                     bytes_left_in = left_dec;
                     if (left_dec == 8'd0) begin
                        phase_in = PH_CHK;
                     end
                     result.byte_value = data_byte;
                     result.location   = cur_addr + {8'd0, cur_index};
                     case (cur_type)
                        REC_NAME: begin
                           result.valid    = 1'b1;
                           result.kind     = KIND_NAME;
                           result.location = {8'd0, cur_index};
                        end
                        REC_INSTR: begin
                           result.valid = 1'b1;
                           result.kind  = KIND_INSTR;
                        end
                        REC_DATA: begin
                           result.valid = 1'b1;
                           result.kind  = KIND_DATA;
                        end
                        default: result.valid = 1'b0;
                     endcase
                  end
                  default: begin
                     phase_in           = PH_TERM;
                     result.valid       = 1'b1;
                     result.checksum_ok = (sum_next == SUM_GOOD);
                     if (cur_type == REC_START) begin
                        result.kind     = KIND_DONE;
                        result.location = cur_addr;
                     end else begin
                        result.kind = KIND_END;
                     end
                  end
               endcase
            end
         end
         PH_TERM: begin
            phase_in = (cur_type == REC_START) ? PH_DONE : PH_S;
         end
         default: phase_in = ph;
      endcase

      if (!result.valid) begin
         result.location   = 16'd0;
         result.byte_value = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_S;
         rec_type_ff   <= 4'd0;
         bytes_left_ff <= 8'd0;
         byte_index_ff <= 8'd0;
         rec_addr_ff   <= 16'd0;
         sum_ff        <= 8'd0;
         high_nib_ff   <= 4'd0;
         nib_pend_ff   <= 1'b0;
      end else if (take) begin
         phase_ff      <= phase_in;
         rec_type_ff   <= rec_type_in;
         bytes_left_ff <= bytes_left_in;
         byte_index_ff <= byte_index_in;
         rec_addr_ff   <= rec_addr_in;
         sum_ff        <= sum_in;
         high_nib_ff   <= high_nib_in;
         nib_pend_ff   <= nib_pend_in;
      end
   end

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (take && !new_load && phase_ff == PH_HALT) |-> !result.valid)
      else $error("result produced while halted");

   a_pend_phase: assert property (@(posedge clock) disable iff (reset)
      nib_pend_ff |-> (phase_ff == PH_LEN || phase_ff == PH_ADDR ||
                       phase_ff == PH_DATA || phase_ff == PH_CHK || phase_ff == PH_HALT))
      else $error("half byte pending outside a hex field");

   a_end_to_term: assert property (@(posedge clock) disable iff (reset)
      (take && result.valid && (result.kind == KIND_END || result.kind == KIND_DONE))
         |=> phase_ff == PH_TERM)
      else $error("record end not followed by terminator phase");

endmodule

[rtl/srecord_stream_loader.sv]
// A request is registered, then parsed once the output register is free; its result is registered and put on rsp.
// Throughput: one request per cycle, with or without a result, while rsp_tready is high.
// A request is taken while an earlier result still waits in the output register.
// Reset (synchronous, active high) empties both registers and returns the parser
// to the start of a file, waiting for the S of the first record.
module srecord_stream_loader
   import srl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tuser,   // [0] new_load
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] location, [23:16] byte_value, [24] checksum_ok
   output logic [2:0]  rsp_tuser    // [2:0] kind
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_new_ff;

   logic        out_valid_ff, out_valid_in;
   kind_type    out_kind_ff;
   logic [15:0] out_loc_ff;
   logic [7:0]  out_byte_ff;
   logic        out_ok_ff;

   logic       advance;
   logic       req_accept;
   result_type result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = result.valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_tdata;
         in_new_ff  <= req_tuser;
      end
      if (advance) begin
         out_kind_ff <= result.kind;
         out_loc_ff  <= result.location;
         out_byte_ff <= result.byte_value;
         out_ok_ff   <= result.checksum_ok;
      end
   end

   srl_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .take     (advance),
      .char_in  (in_char_ff),
      .new_load (in_new_ff),
      .result   (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {7'd0, out_ok_ff, out_byte_ff, out_loc_ff};

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= KIND_ERR)
      else $error("result kind out of range");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_ERR) |-> (rsp_tdata == 32'd0))
      else $error("format error carries payload");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |=> in_valid_ff)
      else $error("pending request dropped while output stalled");

endmodule

[tb/srecord_stream_loader_test.sv]
`timescale 1ns / 100ps

module srecord_stream_loader_test
   import srl_pkg::*;
();

   typedef struct packed {
      kind_type    kind;
      logic [15:0] location;
      logic [7:0]  value;
      logic        ok;
   } load_event_type;

   class load_scoreboard;
      phase_type   phase;
      logic [3:0]  rec_type;
      logic [7:0]  bytes_left;
      logic [7:0]  byte_idx;
      logic [7:0]  run_sum;
      logic [15:0] rec_addr;
      logic [3:0]  hi_nib;
      logic        nib_pending;
      load_event_type load_events[$];
      int          errors;
      int          chars_parsed;

      function new();
         clear();
         errors = 0;
         chars_parsed = 0;
      endfunction

      static function int hex_nibble(logic [7:0] c);
         if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
         if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + 10;
         if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - CHAR_LA) + 10;
         return -1;
      endfunction

      function void clear();
         phase = PH_S;
         rec_type = '0;
         bytes_left = '0;
         byte_idx = '0;
         rec_addr = '0;
         run_sum = '0;
         hi_nib = '0;
         nib_pending = 1'b0;
      endfunction

      function void push(kind_type k, logic [15:0] loc, logic [7:0] v, logic ok);
         load_event_type e;
         e.kind = k;
         e.location = loc;
         e.value = v;
         e.ok = ok;
         load_events.push_back(e);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function int pending();
         return load_events.size();
      endfunction

      function void parse_char(logic [7:0] c, logic restart);
         int         nib;
         logic [7:0] b;
         logic [7:0] idx;
         if (restart) clear();
         if (phase != PH_DONE && phase != PH_HALT) chars_parsed++;
         case (phase)
            PH_S: begin
               if (c != CHAR_S) begin
                  phase = PH_HALT;
                  push(KIND_ERR, 16'h0000, 8'h00, 1'b0);
               end else begin
                  run_sum = '0;
                  rec_addr = '0;
                  nib_pending = 1'b0;
                  phase = PH_TYPE;
               end
            end
            PH_TYPE: begin
               case (c)
                  CHAR_0: rec_type = REC_NAME;
                  CHAR_1: rec_type = REC_INSTR;
                  CHAR_2: rec_type = REC_DATA;
                  CHAR_9: rec_type = REC_START;
                  default: rec_type = REC_OTHER;
               endcase
               phase = PH_LEN;
            end
            PH_LEN, PH_ADDR, PH_DATA, PH_CHK: begin
               nib = hex_nibble(c);
               if (nib < 0) begin
                  phase = PH_HALT;
                  push(KIND_ERR, 16'h0000, 8'h00, 1'b0);
               end else if (!nib_pending) begin
                  hi_nib = nib[3:0];
                  nib_pending = 1'b1;
               end else begin
                  nib_pending = 1'b0;
                  b = {hi_nib, nib[3:0]};
                  run_sum = run_sum + b;
                  case (phase)
                     PH_LEN: begin
                        bytes_left = (b >= LEN_OVERHEAD) ? b - LEN_OVERHEAD : 8'h00;
                        byte_idx = '0;
                        rec_addr = '0;
                        phase = PH_ADDR;
                     end
                     PH_ADDR: begin
                        rec_addr = {rec_addr[7:0], b};
                        byte_idx++;
                        if (byte_idx >= ADDR_COUNT) begin
                           byte_idx = '0;
                           phase = (bytes_left != 0) ? PH_DATA : PH_CHK;
                        end
                     end
                     PH_DATA: begin
                        idx = byte_idx;
                        byte_idx++;
                        bytes_left--;
                        if (bytes_left == 0) phase = PH_CHK;
                        case (rec_type)
                           REC_NAME: push(KIND_NAME, {8'h00, idx}, b, 1'b0);
                           REC_INSTR: push(KIND_INSTR, rec_addr + 16'(idx), b, 1'b0);
                           REC_DATA: push(KIND_DATA, rec_addr + 16'(idx), b, 1'b0);
                           default: ;
                        endcase
                     end
                     default: begin
                        phase = PH_TERM;
                        if (rec_type == REC_START)
                           push(KIND_DONE, rec_addr, 8'h00, run_sum == SUM_GOOD);
                        else
                           push(KIND_END, 16'h0000, 8'h00, run_sum == SUM_GOOD);
                     end
                  endcase
               end
            end
            PH_TERM: phase = (rec_type == REC_START) ? PH_DONE : PH_S;
            default: ;
         endcase
      endfunction

      function void check_load_event(logic [2:0] k, logic [31:0] d);
         load_event_type e;
         if (load_events.size() == 0) begin
            flag($sformatf("unexpected response kind %0d tdata %h", k, d));
            return;
         end
         e = load_events.pop_front();
         if (k !== e.kind || d[15:0] !== e.location || d[23:16] !== e.value ||
             d[24] !== e.ok)
            flag($sformatf("mismatch: expected kind %0d loc %h byte %h ok %b, got %s",
                           e.kind, e.location, e.value, e.ok,
                           $sformatf("kind %0d loc %h byte %h ok %b",
                                     k, d[15:0], d[23:16], d[24])));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   load_scoreboard sb;
   bit             idle_on = 1'b1;
   int             gap_pct = 20;

   srecord_stream_loader dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_load_event(rsp_tuser, rsp_tdata);
   end

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 99) < 20) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   task automatic send_char(input logic [7:0] c, input logic restart);
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tuser <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.parse_char(c, restart);
      if (idle_on && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_line(input logic [7:0] q[$], input bit restart);
      foreach (q[i]) send_char(q[i], restart && i == 0);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   function automatic void put_hex(ref logic [7:0] q[$], input logic [7:0] b);
      logic [7:0] nib;
      for (int i = 1; i >= 0; i--) begin
         nib = 8'(b[i*4 +: 4]);
         if (nib < 10) q.push_back(CHAR_0 + nib);
         else q.push_back(($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + nib - 8'd10);
      end
   endfunction

   function automatic void fill_payload(ref logic [7:0] p[$], input int n);
      p.delete();
      repeat (n) p.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void build_record(ref logic [7:0] q[$], input logic [7:0] type_ch,
                                        input logic [15:0] addr, input logic [7:0] payload[$],
                                        input bit short_len, input bit bad_sum);
      logic [7:0] len;
      logic [7:0] sum;
      int         n;
      q.delete();
      n = short_len ? 0 : payload.size();
      len = short_len ? 8'($urandom_range(0, 2)) : 8'(n + 3);
      sum = len + addr[15:8] + addr[7:0];
      q.push_back(CHAR_S);
      q.push_back(type_ch);
      put_hex(q, len);
      put_hex(q, addr[15:8]);
      put_hex(q, addr[7:0]);
      for (int i = 0; i < n; i++) begin
         put_hex(q, payload[i]);
         sum = sum + payload[i];
      end
      sum = ~sum;
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
      put_hex(q, sum);
      q.push_back($urandom_range(0, 9) < 7 ? 8'h0A : 8'($urandom_range(0, 255)));
   endfunction

   task automatic run_file();
      logic [7:0]  q[$];
      logic [7:0]  payload[$];
      logic [7:0]  type_ch;
      logic [7:0]  c;
      logic [15:0] addr;
      int          n_rec;
      int          r;
      int          keep;
      bit          restart;
      bit          broken;
      restart = 1'b1;
      case ($urandom_range(0, 2))
         0: gap_pct = 0;
         1: gap_pct = 10;
         default: gap_pct = 35;
      endcase
      n_rec = $urandom_range(1, 6);
      for (int k = 0; k < n_rec + 2; k++) begin
         r = $urandom_range(0, 99);
         if (k == 0) begin
            if (r >= 70) continue;
            type_ch = CHAR_0;
         end else if (k == n_rec + 1) begin
            if (r >= 75) break;
            type_ch = CHAR_9;
         end else if (r < 45) type_ch = CHAR_1;
         else if (r < 80) type_ch = CHAR_2;
         else if (r < 90) type_ch = CHAR_0;
         else type_ch = 8'($urandom_range(0, 255));
         r = $urandom_range(0, 99);
         if (r < 2)
            fill_payload(payload, $urandom_range(0, 3) == 0 ? 252 : $urandom_range(100, 252));
         else
            fill_payload(payload, type_ch == CHAR_9 ? $urandom_range(0, 3)
                                                    : $urandom_range(0, 12));
         addr = ($urandom_range(0, 5) == 0) ? 16'hFFF8 + 16'($urandom_range(0, 7))
                                            : 16'($urandom);
         build_record(q, type_ch, addr, payload, r >= 2 && r < 9, $urandom_range(0, 99) < 15);
         broken = $urandom_range(0, 99) < 6;
         if (broken) begin
            if ($urandom_range(0, 1)) begin
               do c = 8'($urandom_range(0, 255)); while (c == CHAR_S);
               q[0] = c;
            end else begin
               do c = 8'($urandom_range(0, 255));
               while (load_scoreboard::hex_nibble(c) >= 0);
               q[$urandom_range(2, q.size() - 2)] = c;
            end
         end else if ($urandom_range(0, 99) < 3) begin
            // cut the record short; the next file restarts mid-record
            keep = $urandom_range(1, q.size() - 1);
            while (q.size() > keep) void'(q.pop_back());
            broken = 1'b1;
         end
         send_line(q, restart);
         restart = 1'b0;
         if (broken || type_ch == CHAR_9) break;
      end
      repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
   endtask

   initial begin
      logic [7:0] q[$];
      logic [7:0] payload[$];
      bit         drained;
      drained = 1'b0;
      sb = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 8'h00;
      req_tuser <= 1'b0;
      rsp_tready <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_char("x", 1'b1);
      send_char(CHAR_S, 1'b0);
      payload.push_back(8'hFF);
      payload.push_back(8'h00);
      build_record(q, CHAR_1, 16'hFFFF, payload, 1'b0, 1'b0);
      send_line(q, 1'b1);
      payload.delete();
      build_record(q, CHAR_9, 16'h8000, payload, 1'b1, 1'b1);
      send_line(q, 1'b0);
      send_char("Z", 1'b0);
      send_char(CHAR_S, 1'b1);
      send_char("3", 1'b0);
      send_char("G", 1'b0);

      while (sb.chars_parsed < 1900) begin
         if (!drained && sb.chars_parsed >= 900) begin
            drain();
            drained = 1'b1;
         end
         if (sb.chars_parsed >= 1650) idle_on = 1'b0;
         run_file();
      end
      req_tvalid <= 1'b0;

      for (int i = 0; i < 5000 && sb.pending() > 0; i++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.pending() > 0)
         sb.flag($sformatf("%0d expected responses never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
